/* hdl/gbl_pkg.sv */
`default_nettype none

package gbl_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int POS_W    = ADDR_W + 1;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_READ      = 2'd2,
        OP_NOP       = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [POS_W-1:0]    cursor;
        logic [7:0]          ch;
        logic [ADDR_W-1:0]   ridx;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

`default_nettype wire

/* hdl/gbl_req_if.sv */
`default_nettype none

interface gbl_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [8:0] cursor_column;
    logic [7:0] character;
    logic [7:0] read_index;

    modport source (output valid, output operation, output cursor_column,
                    output character, output read_index, input ready);
    modport sink   (input valid, input operation, input cursor_column,
                    input character, input read_index, output ready);
endinterface

`default_nettype wire

/* hdl/gbl_rsp_if.sv */
`default_nettype none

interface gbl_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic       index_in_gap;
    logic [8:0] gap_position;
    logic [8:0] free_space;
    logic [1:0] status;

    modport source (output valid, output read_byte, output index_in_gap,
                    output gap_position, output free_space, output status,
                    input ready);
    modport sink   (input valid, input read_byte, input index_in_gap,
                    input gap_position, input free_space, input status,
                    output ready);
endinterface

`default_nettype wire

/* hdl/gbl_front.sv */
`default_nettype none

module gbl_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    gbl_req_if.sink               req,
    output gbl_pkg::q_head_t      head,
    input  wire logic             pop
);

    gbl_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    gbl_pkg::cmd_t cmd_in;
    logic          push;
    logic          take;

    always_comb
    begin
        cmd_in.cursor = req.cursor_column;
        cmd_in.ch     = req.character;
        cmd_in.ridx   = req.read_index;
        case (req.operation)
            gbl_pkg::OP_INSERT:    cmd_in.kind = gbl_pkg::OP_INSERT;
            gbl_pkg::OP_BACKSPACE: cmd_in.kind = gbl_pkg::OP_BACKSPACE;
            gbl_pkg::OP_READ:      cmd_in.kind = gbl_pkg::OP_READ;
            default:               cmd_in.kind = gbl_pkg::OP_NOP;
        endcase
    end

    assign req.ready = (count_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign take      = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (take && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

/* hdl/gbl_back.sv */
`default_nettype none

module gbl_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire gbl_pkg::q_head_t head,
    output logic                  pop,
    gbl_rsp_if.source             rsp
);

    localparam int AW = gbl_pkg::ADDR_W;
    localparam int PW = gbl_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_APPLY,
        S_RDWAIT,
        S_FINISH
    } state_t;

    logic [7:0] mem [gbl_pkg::CAPACITY];

    state_t            state_reg, state_next;
    gbl_pkg::cmd_t     cmd_reg, cmd_next;
    logic [PW-1:0]     gs_reg, gs_next;
    logic [PW-1:0]     gl_reg, gl_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [7:0]        res_byte_reg, res_byte_next;
    logic              res_gap_reg, res_gap_next;
    gbl_pkg::status_t  res_st_reg, res_st_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_gap_reg, out_gap_next;
    logic [PW-1:0]     out_pos_reg, out_pos_next;
    logic [PW-1:0]     out_free_reg, out_free_next;
    gbl_pkg::status_t  out_st_reg, out_st_next;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;

    logic [PW-1:0]     text_len;
    logic [PW-1:0]     gap_end;
    logic [PW-1:0]     ridx_ext;

    assign text_len = PW'(gbl_pkg::CAPACITY) - gl_reg;
    assign gap_end  = gs_reg + gl_reg;
    assign ridx_ext = {1'b0, head.cmd.ridx};

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        gs_next        = gs_reg;
        gl_next        = gl_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        res_byte_next  = res_byte_reg;
        res_gap_next   = res_gap_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_byte_next  = out_byte_reg;
        out_gap_next   = out_gap_reg;
        out_pos_next   = out_pos_reg;
        out_free_next  = out_free_reg;
        out_st_next    = out_st_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head.cmd.ridx;
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop           = 1'b1;
                    cmd_next      = head.cmd;
                    res_byte_next = 8'd0;
                    res_gap_next  = 1'b0;
                    res_st_next   = gbl_pkg::ST_OK;
                    pend_next     = 1'b0;
                    case (head.cmd.kind)
                        gbl_pkg::OP_INSERT:
                        begin
                            if (head.cmd.cursor > text_len)
                            begin
                                res_st_next = gbl_pkg::ST_RANGE;
                                state_next  = S_FINISH;
                            end
                            else if (gl_reg == '0)
                            begin
                                res_st_next = gbl_pkg::ST_FULL;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        gbl_pkg::OP_BACKSPACE:
                        begin
                            if (head.cmd.cursor > text_len)
                            begin
                                res_st_next = gbl_pkg::ST_RANGE;
                                state_next  = S_FINISH;
                            end
                            else if (head.cmd.cursor == '0)
                            begin
                                res_st_next = gbl_pkg::ST_EMPTY;
                                state_next  = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        gbl_pkg::OP_READ:
                        begin
                            rd_en        = 1'b1;
                            rd_addr      = head.cmd.ridx;
                            res_gap_next = (ridx_ext >= gs_reg) && (ridx_ext < gap_end);
                            state_next   = S_RDWAIT;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // write back the byte read on the previous cycle
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg;
                    wr_data = rd_data_reg;
                end
                if (gs_reg < cmd_reg.cursor)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = gap_end[AW-1:0];
                    pend_addr_next = gs_reg[AW-1:0];
                    gs_next        = gs_reg + PW'(1);
                    pend_next      = 1'b1;
                end
                else if (gs_reg > cmd_reg.cursor)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = AW'(gs_reg - PW'(1));
                    pend_addr_next = AW'(gap_end - PW'(1));
                    gs_next        = gs_reg - PW'(1);
                    pend_next      = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        state_next = S_APPLY;
                    end
                end
            end

            S_APPLY:
            begin
                if (cmd_reg.kind == gbl_pkg::OP_INSERT)
                begin
                    wr_en   = 1'b1;
                    wr_addr = gs_reg[AW-1:0];
                    wr_data = cmd_reg.ch;
                    gs_next = gs_reg + PW'(1);
                    gl_next = gl_reg - PW'(1);
                end
                else
                begin
                    gs_next = gs_reg - PW'(1);
                    gl_next = gl_reg + PW'(1);
                end
                state_next = S_FINISH;
            end

            S_RDWAIT:
            begin
                res_byte_next = rd_data_reg;
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_byte_reg;
                    out_gap_next   = res_gap_reg;
                    out_pos_next   = gs_reg;
                    out_free_next  = gl_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            gs_reg        <= '0;
            gl_reg        <= PW'(gbl_pkg::CAPACITY);
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            res_byte_reg  <= '0;
            res_gap_reg   <= 1'b0;
            res_st_reg    <= gbl_pkg::ST_OK;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_gap_reg   <= 1'b0;
            out_pos_reg   <= '0;
            out_free_reg  <= '0;
            out_st_reg    <= gbl_pkg::ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            gs_reg        <= gs_next;
            gl_reg        <= gl_next;
            pend_reg      <= pend_next;
            pend_addr_reg <= pend_addr_next;
            res_byte_reg  <= res_byte_next;
            res_gap_reg   <= res_gap_next;
            res_st_reg    <= res_st_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            out_gap_reg   <= out_gap_next;
            out_pos_reg   <= out_pos_next;
            out_free_reg  <= out_free_next;
            out_st_reg    <= out_st_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_byte    = out_byte_reg;
    assign rsp.index_in_gap = out_gap_reg;
    assign rsp.gap_position = out_pos_reg;
    assign rsp.free_space   = out_free_reg;
    assign rsp.status       = out_st_reg;

endmodule

`default_nettype wire

/* hdl/gap_buffer_line_editor.sv */
// Gap buffer holding one line of text in a 256-byte store.
// req channel: operation (insert, backspace, read raw entry), cursor column,
// character and read index. rsp channel: one result per request with the
// read byte, gap flag, gap start, gap length and status.
// A two-entry command queue sits between the request side and the executor,
// so requests are taken while an earlier one is still being carried out.
// Out-of-range, full, delete-at-column-0 and no-op cases go straight to
// the result; a read waits for the store's registered read data; an insert
// or backspace with the gap away from the cursor first walks the gap to
// the cursor, one byte per cycle through a store with one read and one
// write port (read one byte, write it back on the next cycle, overlapped).
// The executor handles one item at a time and takes the next command only
// after the current result has been handed to the output register.
// Reset empties the queue and sets the gap to cover the whole store; store
// contents stay undefined until written. No clearing pass is needed.
// A stalled rsp holds its result in the output register; the executor waits
// with the next result and the queue fills, then req.ready drops.

`default_nettype none

module gap_buffer_line_editor (
    input  wire logic clk,
    input  wire logic rst_n,
    gbl_req_if.sink   req,
    gbl_rsp_if.source rsp
);

    gbl_pkg::q_head_t head;
    logic             pop;

    gbl_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    gbl_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
